// File: sv/http_part_body_extractor_unit_assert.svh
// Assertion macros shared by the extractor RTL.
// Each macro expects clk and arst_n in scope.
`ifndef HTTP_PART_BODY_EXTRACTOR_UNIT_ASSERT_SVH
`define HTTP_PART_BODY_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define HPBE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hpbe assertion failed (same cycle)");

// Next-cycle implication, checked outside reset
`define HPBE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hpbe assertion failed (next cycle)");

`endif

// File: sv/hpbe_pkg.sv
package hpbe_pkg;

	// Framing mode of the byte stream
	typedef enum logic [1:0] {
		MODE_HEADER = 2'd0,
		MODE_BODY   = 2'd1,
		MODE_SKIP   = 2'd2
	} mode_t;

	// Progress of the length value parse
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_LEAD   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	localparam int unsigned LEN_W   = 30;
	localparam int unsigned TAG_LEN = 16;
	localparam int unsigned SKIP_W  = 3;

	localparam logic [SKIP_W-1:0] SEP_BYTES = 3'd4;

	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;

	// "Content-length: "
	localparam logic [7:0] TAG_TEXT [TAG_LEN] = '{
		8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
		8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
	};

	// Header tracker status toward the framing control
	typedef struct packed {
		logic             done;
		logic [LEN_W-1:0] len;
	} hdr_status_t;

endpackage

// File: sv/http_part_body_extractor_unit.sv
// HTTP part body extractor. Bytes of concatenated HTTP parts enter one per
// cycle unless the input stalls; each header is searched for "Content-length: "
// and its decimal value, the header ends at CR LF CR LF, then that many body
// bytes leave with part_last on the final one, and four separator bytes are
// dropped. A missing tag or a negative value gives an empty body. end_of_stream
// returns the block to header search after its byte. Throughput is one item
// per cycle, sustained while the output is not stalled; an item passes an
// input register and a result register, and a body byte is presented on the
// output once it moves on into the result register. The rate is set by the
// per-byte update of the header tracker and framing counters. The input side
// stalls only while the result register holds an item that is stalled.
module http_part_body_extractor_unit
	import hpbe_pkg::*;
#(
	parameter int unsigned MAX_LENGTH_DIGITS = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] body_byte,
	output logic       part_last
);

	`include "http_part_body_extractor_unit_assert.svh"

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              eos_s1;
	logic              advance;

	mode_t             mode_q, mode_n;
	logic [LEN_W-1:0]  rem_q, rem_n;
	logic [SKIP_W-1:0] skip_q, skip_n;

	logic              res_valid;
	logic              res_last;
	logic              hdr_step;
	logic              hdr_clr;
	hdr_status_t       hdr;

	logic              out_valid_q;
	logic [7:0]        body_byte_q;
	logic              part_last_q;

	// item in stage 1 moves on when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			eos_s1  <= end_of_stream;
		end
	end

	// header tag, value and end tracking
	assign hdr_step = advance && (mode_q == MODE_HEADER);
	assign hdr_clr  = advance && (eos_s1 || ((mode_q == MODE_SKIP) && (skip_q <= 3'd1)));

	hpbe_hdr_track #(
		.MAX_LENGTH_DIGITS(MAX_LENGTH_DIGITS)
	) u_hdr (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (hdr_step),
		.clr   (hdr_clr),
		.data  (data_s1),
		.status(hdr)
	);

	// framing outputs
	always_comb begin
		res_valid = 1'b0;
		res_last  = 1'b0;
		case (mode_q)
			MODE_BODY: begin
				res_valid = 1'b1;
				res_last  = (rem_q <= LEN_W'(1));
			end
			default: begin
				res_valid = 1'b0;
				res_last  = 1'b0;
			end
		endcase
	end

	// framing next state
	always_comb begin
		mode_n = mode_q;
		rem_n  = rem_q;
		skip_n = skip_q;
		if (advance) begin
			case (mode_q)
				MODE_BODY: begin
					rem_n = (rem_q != '0) ? rem_q - LEN_W'(1) : rem_q;
					if (rem_q <= LEN_W'(1)) begin
						skip_n = SEP_BYTES;
						mode_n = MODE_SKIP;
					end
				end
				MODE_SKIP: begin
					skip_n = (skip_q != '0) ? skip_q - SKIP_W'(1) : skip_q;
					if (skip_q <= SKIP_W'(1)) begin
						mode_n = MODE_HEADER;
					end
				end
				MODE_HEADER: begin
					if (hdr.done) begin
						if (hdr.len != '0) begin
							rem_n  = hdr.len;
							mode_n = MODE_BODY;
						end else begin
							skip_n = SEP_BYTES;
							mode_n = MODE_SKIP;
						end
					end
				end
				default: begin
					mode_n = MODE_HEADER;
				end
			endcase
			if (eos_s1) begin
				mode_n = MODE_HEADER;
				rem_n  = '0;
				skip_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HEADER;
			rem_q  <= '0;
			skip_q <= '0;
		end else begin
			mode_q <= mode_n;
			rem_q  <= rem_n;
			skip_q <= skip_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			body_byte_q <= data_s1;
			part_last_q <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign body_byte = body_byte_q;
	assign part_last = part_last_q;

	// body count is live exactly in body mode
	`HPBE_ASSERT_SAME(a_rem_body, mode_q == MODE_BODY, rem_q != '0)
	`HPBE_ASSERT_SAME(a_rem_idle, mode_q != MODE_BODY, rem_q == '0)
	// separator count stays within the separator length while skipping
	`HPBE_ASSERT_SAME(a_skip_range, mode_q == MODE_SKIP, (skip_q != '0) && (skip_q <= SEP_BYTES))
	// a body byte that moves on always lands in the result register
	`HPBE_ASSERT_NEXT(a_res_load, advance && res_valid, out_valid_q)

endmodule

// File: sv/hpbe_hdr_track.sv
module hpbe_hdr_track
	import hpbe_pkg::*;
#(
	parameter int unsigned MAX_LENGTH_DIGITS = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        clr,
	input  logic [7:0]  data,
	output hdr_status_t status
);

	localparam logic [3:0] DIGITS_MAX = 4'(MAX_LENGTH_DIGITS);

	logic [1:0]       end_cnt_q, end_cnt_n;
	logic [4:0]       tag_idx_q, tag_idx_n;
	logic             tag_found_q, tag_found_n;
	phase_t           phase_q, phase_n;
	logic [3:0]       digit_cnt_q, digit_cnt_n;
	logic [LEN_W-1:0] len_q, len_n;

	logic             is_digit;
	logic             tag_hit;
	logic             take_ok;
	logic [3:0]       digit_val;
	logic [LEN_W-1:0] len_x10;
	logic             done;

	assign is_digit  = (data >= CHR_ZERO) && (data <= CHR_NINE);
	assign digit_val = 4'(data - CHR_ZERO);
	assign tag_hit   = !tag_idx_q[4] && (data == TAG_TEXT[tag_idx_q[3:0]]);
	assign take_ok   = digit_cnt_q < DIGITS_MAX;
	// value * 10 + digit as shift-add, wrapped to the register width
	assign len_x10   = {len_q[LEN_W-4:0], 3'b000} + {len_q[LEN_W-2:0], 1'b0}
		+ {{(LEN_W-4){1'b0}}, digit_val};

	// tag search and value parse
	always_comb begin
		tag_idx_n   = tag_idx_q;
		tag_found_n = tag_found_q;
		phase_n     = phase_q;
		digit_cnt_n = digit_cnt_q;
		len_n       = len_q;
		if (!tag_found_q) begin
			if (tag_hit) begin
				tag_idx_n = tag_idx_q + 5'd1;
				if (tag_idx_q == 5'(TAG_LEN - 1)) begin
					tag_found_n = 1'b1;
					phase_n     = PH_LEAD;
				end
			end else begin
				tag_idx_n = (data == TAG_TEXT[0]) ? 5'd1 : 5'd0;
			end
		end else begin
			case (phase_q)
				PH_LEAD: begin
					if (data == CHR_SPACE) begin
						phase_n = PH_LEAD;
					end else if (data == CHR_PLUS) begin
						phase_n = PH_DIGITS;
					end else if (data == CHR_MINUS) begin
						len_n   = '0;
						phase_n = PH_DONE;
					end else if (is_digit) begin
						if (take_ok) begin
							len_n       = len_x10;
							digit_cnt_n = digit_cnt_q + 4'd1;
						end
						phase_n = PH_DIGITS;
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						if (take_ok) begin
							len_n       = len_x10;
							digit_cnt_n = digit_cnt_q + 4'd1;
						end
					end else begin
						phase_n = PH_DONE;
					end
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
	end

	// CR LF CR LF tracking
	always_comb begin
		done = 1'b0;
		if (data == CHR_CR) begin
			end_cnt_n = (end_cnt_q == 2'd2) ? 2'd3 : 2'd1;
		end else if (data == CHR_LF) begin
			if (end_cnt_q == 2'd1) begin
				end_cnt_n = 2'd2;
			end else begin
				end_cnt_n = 2'd0;
				done      = (end_cnt_q == 2'd3);
			end
		end else begin
			end_cnt_n = 2'd0;
		end
	end

	// length is only ever nonzero once the tag was seen
	assign status.done = done;
	assign status.len  = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_cnt_q   <= 2'd0;
			tag_idx_q   <= 5'd0;
			tag_found_q <= 1'b0;
			phase_q     <= PH_IDLE;
			digit_cnt_q <= 4'd0;
			len_q       <= '0;
		end else if (clr || (step && done)) begin
			end_cnt_q   <= 2'd0;
			tag_idx_q   <= 5'd0;
			tag_found_q <= 1'b0;
			phase_q     <= PH_IDLE;
			digit_cnt_q <= 4'd0;
			len_q       <= '0;
		end else if (step) begin
			end_cnt_q   <= end_cnt_n;
			tag_idx_q   <= tag_idx_n;
			tag_found_q <= tag_found_n;
			phase_q     <= phase_n;
			digit_cnt_q <= digit_cnt_n;
			len_q       <= len_n;
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb
	import hpbe_pkg::*;
();

	localparam int unsigned DIGITS_MAX  = 9;
	localparam int unsigned STUCK_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 12;

	// one expected body byte
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} body_exp_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_stream = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] body_byte;
	logic       part_last;

	http_part_body_extractor_unit #(
		.MAX_LENGTH_DIGITS(DIGITS_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.body_byte    (body_byte),
		.part_last    (part_last)
	);

	// expected body bytes, oldest first
	body_exp_t   body_q[$];
	// bytes of the part being built
	logic [7:0]  frame_q[$];

	int unsigned mismatch_cnt = 0;
	int unsigned sent_cnt = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned eos_per_mille = 0;

	// deframer state as seen from outside
	mode_t            fr_mode;
	logic [1:0]       end_cnt;
	logic [4:0]       tag_idx;
	logic             tag_seen;
	phase_t           num_ph;
	logic [3:0]       ndig;
	logic [LEN_W-1:0] len_acc;
	logic [LEN_W-1:0] body_left;
	logic [SKIP_W-1:0] sep_left;

	initial begin
		forever #5 clk = ~clk;
	end

	// header tracking back to the start of a header
	task automatic clear_hdr_state();
		end_cnt  = '0;
		tag_idx  = '0;
		tag_seen = 1'b0;
		num_ph   = PH_IDLE;
		ndig     = '0;
		len_acc  = '0;
	endtask

	task automatic deframe_reset();
		fr_mode   = MODE_HEADER;
		clear_hdr_state();
		body_left = '0;
		sep_left  = '0;
	endtask

	function automatic void add_digit(input logic [7:0] b);
		if (ndig < DIGITS_MAX) begin
			len_acc = LEN_W'(len_acc * 10 + LEN_W'(b - CHR_ZERO));
			ndig++;
		end
	endfunction

	// advance the deframer by one accepted byte, queue any body byte
	task automatic deframe_byte(input logic [7:0] b, input logic eos);
		logic             is_digit;
		logic             hdr_end;
		logic             last;
		logic [LEN_W-1:0] hdr_len;
		is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
		hdr_end  = 1'b0;
		case (fr_mode)
		MODE_BODY: begin
			if (body_left != 0)
				body_left--;
			last = (body_left == 0);
			body_q.push_back('{data: b, last: last});
			if (last) begin
				sep_left = SEP_BYTES;
				fr_mode  = MODE_SKIP;
			end
		end
		MODE_SKIP: begin
			if (sep_left != 0)
				sep_left--;
			if (sep_left == 0) begin
				clear_hdr_state();
				fr_mode = MODE_HEADER;
			end
		end
		default: begin
			// tag search, then value parse after the first match
			if (!tag_seen) begin
				if (tag_idx < TAG_LEN && b == TAG_TEXT[tag_idx[3:0]]) begin
					tag_idx++;
					if (tag_idx == TAG_LEN) begin
						tag_seen = 1'b1;
						num_ph   = PH_LEAD;
					end
				end else begin
					tag_idx = (b == TAG_TEXT[0]) ? 5'd1 : 5'd0;
				end
			end else begin
				case (num_ph)
				PH_LEAD: begin
					if (b == CHR_SPACE) begin
					end else if (b == CHR_PLUS) begin
						num_ph = PH_DIGITS;
					end else if (b == CHR_MINUS) begin
						len_acc = '0;
						num_ph  = PH_DONE;
					end else if (is_digit) begin
						add_digit(b);
						num_ph = PH_DIGITS;
					end else begin
						num_ph = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit)
						add_digit(b);
					else
						num_ph = PH_DONE;
				end
				default: ;
				endcase
			end
			// CR LF CR LF tracking
			if (b == CHR_CR) begin
				end_cnt = (end_cnt == 2'd2) ? 2'd3 : 2'd1;
			end else if (b == CHR_LF) begin
				hdr_end = (end_cnt == 2'd3);
				end_cnt = (end_cnt == 2'd1) ? 2'd2 : 2'd0;
			end else begin
				end_cnt = 2'd0;
			end
			if (hdr_end) begin
				hdr_len = tag_seen ? len_acc : '0;
				clear_hdr_state();
				if (hdr_len != 0) begin
					body_left = hdr_len;
					fr_mode   = MODE_BODY;
				end else begin
					sep_left = SEP_BYTES;
					fr_mode  = MODE_SKIP;
				end
			end
		end
		endcase
		if (eos)
			deframe_reset();
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// result checker
	always @(posedge clk) begin
		body_exp_t exp_item;
		if (arst_n && out_valid && !out_stall) begin
			if (body_q.size() == 0) begin
				report_mismatch("unexpected body_byte", body_byte, 0);
			end else begin
				exp_item = body_q.pop_front();
				if (body_byte !== exp_item.data)
					report_mismatch("body_byte", body_byte, exp_item.data);
				if (part_last !== exp_item.last)
					report_mismatch("part_last", part_last, exp_item.last);
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on cycles with no handshake on either side
	initial begin : watchdog
		int unsigned stuck_cnt;
		stuck_cnt = 0;
		while (stuck_cnt < STUCK_LIMIT) begin
			@(posedge clk);
			if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
				stuck_cnt++;
			else
				stuck_cnt = 0;
		end
		$display("tb failed");
		$finish;
	end

	// send one item; valid stays high into the next call unless it idles
	task automatic send_byte(input logic [7:0] b, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= b;
		end_of_stream <= eos;
		do
			@(posedge clk);
		while (in_stall);
		deframe_byte(b, eos);
		sent_cnt++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		frame_q.push_back(b);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			frame_q.push_back(s[i]);
	endtask

	task automatic add_crlf();
		frame_q.push_back(CHR_CR);
		frame_q.push_back(CHR_LF);
	endtask

	task automatic add_random(input int unsigned n);
		repeat (n)
			frame_q.push_back(8'($urandom_range(255)));
	endtask

	// header line followed by the blank line
	task automatic add_header(input string line);
		add_text(line);
		add_crlf();
		add_crlf();
	endtask

	// send the built bytes, end_of_stream optionally on the last one
	task automatic send_frame(input logic eos_last);
		logic eos;
		for (int i = 0; i < frame_q.size(); i++) begin
			eos = (eos_last && i == frame_q.size() - 1) ||
				($urandom_range(999) < eos_per_mille);
			send_byte(frame_q[i], eos);
		end
		frame_q.delete();
	endtask

	// hold the sender until every body byte is out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (body_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idle(input int unsigned snd, input int unsigned rcv);
		send_idle_pct = snd;
		recv_idle_pct = rcv;
	endtask

	// plain part with extreme body bytes, then a second part right behind it
	task automatic test_basic_parts();
		add_header("Content-length: 3");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'h5A);
		add_random(SEP_BYTES);
		add_header("Content-length: 1");
		add_byte(8'hA5);
		add_random(SEP_BYTES);
		send_frame(1'b0);
	endtask

	// spaces and plus sign, minus sign, junk before and after digits, long digit run
	task automatic test_value_syntax();
		add_header("Content-length:   +2");
		add_random(2 + SEP_BYTES);
		add_header("Content-length: -5");
		add_random(SEP_BYTES);
		add_header("Content-length: x5");
		add_random(SEP_BYTES);
		add_header("Content-length: 2;x");
		add_random(2 + SEP_BYTES);
		add_header("Content-length: 0000000012345");
		add_random(1 + SEP_BYTES);
		send_frame(1'b0);
	endtask

	// missing tag, repeated tag, tag after a false start, zero length
	task automatic test_header_cases();
		add_header("Host: x");
		add_random(SEP_BYTES);
		add_text("Content-length: 1");
		add_crlf();
		add_header("Content-length: 2");
		add_random(1 + SEP_BYTES);
		add_header("CoContent-length: 1");
		add_random(1 + SEP_BYTES);
		add_header("Content-length: 0");
		add_random(SEP_BYTES);
		send_frame(1'b0);
	endtask

	// end of stream inside a body, on the last body byte, in a header, in the separator
	task automatic test_early_end();
		add_header("Content-length: 5");
		add_random(2);
		send_frame(1'b1);
		add_header("Content-length: 2");
		add_random(2);
		send_frame(1'b1);
		add_text("Content-length: 4");
		add_crlf();
		add_text("X: y");
		send_frame(1'b1);
		add_header("Content-length: 1");
		add_random(3);
		send_frame(1'b1);
		add_header("Content-length: 1");
		add_random(1 + SEP_BYTES);
		send_frame(1'b0);
	endtask

	// random parts: mostly well-formed with random formatting, some noise and broken tags
	task automatic test_random_parts(input int unsigned item_goal);
		int unsigned start_cnt;
		int unsigned kind;
		int unsigned len_val;
		int unsigned sel;
		start_cnt     = sent_cnt;
		eos_per_mille = 2;
		while (sent_cnt - start_cnt < item_goal) begin
			kind = $urandom_range(9);
			if (kind == 0) begin
				// noise rich in CR, LF and tag start
				repeat ($urandom_range(1, 24)) begin
					sel = $urandom_range(4);
					if (sel == 0)
						add_byte(CHR_CR);
					else if (sel == 1)
						add_byte(CHR_LF);
					else if (sel == 2)
						add_byte(TAG_TEXT[0]);
					else
						add_random(1);
				end
				send_frame(1'b0);
			end else begin
				if ($urandom_range(2) == 0) begin
					add_text("Accept: */*");
					add_crlf();
				end
				if (kind == 1) begin
					add_text("Host: h");
				end else begin
					if (kind == 2)
						add_text("Content-lenGth: ");
					else
						add_text("Content-length: ");
					repeat ($urandom_range(2))
						add_byte(CHR_SPACE);
					sel = $urandom_range(9);
					if (sel == 0)
						add_byte(CHR_PLUS);
					else if (sel == 1)
						add_byte(CHR_MINUS);
					if ($urandom_range(9) < 2)
						repeat ($urandom_range(1, 9))
							add_byte(CHR_ZERO);
					if ($urandom_range(99) < 4)
						len_val = $urandom_range(100, 260);
					else
						len_val = $urandom_range(12);
					add_text($sformatf("%0d", len_val));
					if ($urandom_range(4) == 0)
						add_text(";q");
				end
				add_crlf();
				if ($urandom_range(4) == 0) begin
					add_text("Content-length: 7");
					add_crlf();
				end
				add_crlf();
				send_frame(1'b0);
				// body size as the header declared it
				if (fr_mode == MODE_BODY)
					add_random(body_left);
				if (fr_mode != MODE_HEADER)
					add_random(SEP_BYTES);
				send_frame($urandom_range(19) == 0);
			end
		end
		eos_per_mille = 0;
	endtask

	initial begin
		deframe_reset();
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(11, 72);
		test_basic_parts();
		test_value_syntax();
		test_header_cases();
		test_early_end();
		wait_drained();
		test_random_parts(60);

		set_idle(72, 11);
		test_random_parts(60);
		wait_drained();

		set_idle(0, 0);
		test_random_parts(60);

		wait_drained();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatch_cnt == 0 && body_q.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
